### hdl/asi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asi_pkg
// Shared types, codes and constants for the actuator safety interlock.
// ----------------------------------------------------------------------------
package asi_pkg;

  // command codes
  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_ENABLE       = 3'd1;
  localparam logic [2:0] OP_DISABLE      = 3'd2;
  localparam logic [2:0] OP_RESET        = 3'd3;
  localparam logic [2:0] OP_FAULT_INJECT = 3'd4;
  localparam logic [2:0] OP_CLEAR        = 3'd5;
  localparam logic [2:0] OP_UNKNOWN      = 3'd6;
  localparam logic [2:0] OP_OVERFLOW     = 3'd7;

  // operating modes
  localparam logic [1:0] MODE_READY = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_FAULT = 2'd2;

  // fault codes
  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_SETPOINT = 3'd1;
  localparam logic [2:0] FLT_SENSOR   = 3'd2;
  localparam logic [2:0] FLT_TIMEOUT  = 3'd3;
  localparam logic [2:0] FLT_UNKNOWN  = 3'd4;

  // pwm force modes
  localparam logic [1:0] FORCE_NONE = 2'd0;
  localparam logic [1:0] FORCE_LOW  = 2'd1;
  localparam logic [1:0] FORCE_HIGH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SETPOINT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd1;
  localparam logic [1:0] CFG_PWM_PERIOD     = 2'd2;

  localparam logic [9:0]  SETPOINT_CEIL = 10'd1000;
  localparam logic [9:0]  LIMIT_RST     = 10'd1000;
  localparam logic [15:0] TIMEOUT_RST   = 16'd3000;
  localparam logic [15:0] PERIOD_RST    = 16'd1000;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;
  localparam logic [6:0]  DUTY_FULL     = 7'd100;

  // x / 10 = (x * 205) >> 11, exact for x below 1024
  localparam logic [17:0] DIV10_MUL   = 18'd205;
  // x / 100 = (x * ceil(2^30 / 100)) >> 30, exact for x below 2^23
  localparam logic [46:0] DIV100_MUL  = 47'd10737419;
  localparam int          DIV100_SHIFT = 30;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  fault_code;
    logic        drive_enabled;
    logic        fault_held;
    logic [9:0]  active_setpoint;
    logic [6:0]  duty_percent;
    logic [15:0] command_age;
    logic [15:0] last_seq;
  } status_t;

endpackage
`default_nettype wire

### hdl/asi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asi_if
// Valid/ready channels for command items and status result items.
// ----------------------------------------------------------------------------
interface asi_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [15:0] requested_setpoint;
  logic [15:0]        seq_number;

  modport source (output valid, output op, output requested_setpoint, output seq_number,
                  input ready);
  modport sink   (input valid, input op, input requested_setpoint, input seq_number,
                  output ready);
endinterface

interface asi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  fault_code;
  logic        drive_enabled;
  logic        fault_held;
  logic [9:0]  active_setpoint;
  logic [6:0]  duty_percent;
  logic [15:0] command_age;
  logic [15:0] last_seq;
  logic [15:0] compare_value;
  logic [1:0]  force_mode;

  modport source (output valid, output mode, output fault_code, output drive_enabled,
                  output fault_held, output active_setpoint, output duty_percent,
                  output command_age, output last_seq, output compare_value,
                  output force_mode, input ready);
  modport sink   (input valid, input mode, input fault_code, input drive_enabled,
                  input fault_held, input active_setpoint, input duty_percent,
                  input command_age, input last_seq, input compare_value,
                  input force_mode, output ready);
endinterface
`default_nettype wire

### hdl/asi_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asi_state
// Configuration registers and interlock state; computes the next state for
// each accepted item.
// ----------------------------------------------------------------------------
module asi_state import asi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [2:0]  op,
  input  wire logic [15:0] req_sp,
  input  wire logic [15:0] seq_in,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output status_t          state_nxt,
  output logic [15:0]      pwm_period
);

  status_t     state_r;
  logic [9:0]  sp_limit_r;
  logic [15:0] timeout_r;
  logic [15:0] period_r;

  logic [9:0]  lim;
  logic        sp_bad;
  logic [15:0] age_inc;
  logic [17:0] sp_x205;

  function automatic status_t latch_fault(status_t s, logic [2:0] code);
    status_t r;
    r                 = s;
    r.fault_code      = code;
    r.fault_held      = 1'b1;
    r.drive_enabled   = 1'b0;
    r.active_setpoint = '0;
    r.duty_percent    = '0;
    r.mode            = MODE_FAULT;
    return r;
  endfunction

  always_comb begin
    lim     = (sp_limit_r > SETPOINT_CEIL) ? SETPOINT_CEIL : sp_limit_r;
    sp_bad  = req_sp[15] || (req_sp > {6'd0, lim});
    sp_x205 = 18'(req_sp[9:0]) * DIV10_MUL;
    age_inc = (state_r.command_age != AGE_MAX) ? state_r.command_age + 16'd1
                                               : state_r.command_age;
    state_nxt = state_r;

    if (op inside {[OP_ENABLE:OP_UNKNOWN]}) begin
      state_nxt.command_age = '0;
      state_nxt.last_seq    = seq_in;
    end

    case (op)
      OP_TICK: begin
        if (state_r.drive_enabled && state_r.mode == MODE_RUN) begin
          state_nxt.command_age = age_inc;
          if (age_inc >= timeout_r) begin
            state_nxt = latch_fault(state_nxt, FLT_TIMEOUT);
          end
        end
      end
      OP_ENABLE: begin
        if (sp_bad) begin
          state_nxt = latch_fault(state_nxt, FLT_SETPOINT);
        end else if (state_r.fault_held) begin
          // setpoint stays as it was, output forced off
          state_nxt.duty_percent  = '0;
          state_nxt.drive_enabled = 1'b0;
          state_nxt.mode          = MODE_FAULT;
        end else begin
          state_nxt.drive_enabled   = 1'b1;
          state_nxt.active_setpoint = req_sp[9:0];
          state_nxt.duty_percent    = sp_x205[17:11];
          state_nxt.fault_code      = FLT_NONE;
          state_nxt.mode            = MODE_RUN;
        end
      end
      OP_DISABLE: begin
        state_nxt.drive_enabled   = 1'b0;
        state_nxt.active_setpoint = '0;
        state_nxt.duty_percent    = '0;
        if (state_r.fault_held) begin
          state_nxt.mode = MODE_FAULT;
        end else begin
          state_nxt.fault_code = FLT_NONE;
          state_nxt.mode       = MODE_READY;
        end
      end
      OP_RESET: begin
        // a latched fault only clears while the drive is off
        if (!state_r.drive_enabled) begin
          state_nxt.fault_code      = FLT_NONE;
          state_nxt.fault_held      = 1'b0;
          state_nxt.active_setpoint = '0;
          state_nxt.duty_percent    = '0;
          state_nxt.mode            = MODE_READY;
        end
      end
      OP_FAULT_INJECT: begin
        state_nxt = latch_fault(state_nxt, FLT_SENSOR);
      end
      OP_CLEAR: begin
      end
      default: begin
        state_nxt = latch_fault(state_nxt, FLT_UNKNOWN);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= '0;
      sp_limit_r <= LIMIT_RST;
      timeout_r  <= TIMEOUT_RST;
      period_r   <= PERIOD_RST;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETPOINT_LIMIT: sp_limit_r <= cfg_wdata[9:0];
          CFG_TIMEOUT_TICKS:  timeout_r  <= cfg_wdata;
          CFG_PWM_PERIOD:     period_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  assign pwm_period = period_r;

endmodule
`default_nettype wire

### hdl/asi_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asi_pipe
// Three-stage result pipeline: status capture, period times duty, divide by
// one hundred and force decode into the output register.
// ----------------------------------------------------------------------------
module asi_pipe import asi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire status_t     state_nxt,
  input  wire logic [15:0] pwm_period,
  output logic             out_valid,
  input  wire logic        out_ready,
  output status_t          out_status,
  output logic [15:0]      out_compare,
  output logic [1:0]       out_force
);

  logic        v1_r, v2_r, v3_r;
  status_t     s1_r, s2_r, s3_r;
  logic [22:0] prod_r;
  logic [15:0] cmp_r;
  logic [1:0]  force_r;

  logic        adv1, adv2, adv3;
  logic [46:0] quot_full;
  logic [15:0] cmp_nxt;
  logic [1:0]  force_nxt;

  // each stage moves when it is empty or the one after it moves
  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    quot_full = 47'(prod_r) * DIV100_MUL;
    if (s2_r.duty_percent == '0) begin
      cmp_nxt   = '0;
      force_nxt = FORCE_LOW;
    end else if (s2_r.duty_percent >= DUTY_FULL) begin
      cmp_nxt   = pwm_period;
      force_nxt = FORCE_HIGH;
    end else begin
      cmp_nxt   = quot_full[DIV100_SHIFT +: 16];
      force_nxt = FORCE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r <= state_nxt;
    end
    if (adv2 && v1_r) begin
      s2_r   <= s1_r;
      prod_r <= 23'(pwm_period) * 23'(s1_r.duty_percent);
    end
    if (adv3 && v2_r) begin
      s3_r    <= s2_r;
      cmp_r   <= cmp_nxt;
      force_r <= force_nxt;
    end
  end

  assign out_valid   = v3_r;
  assign out_status  = s3_r;
  assign out_compare = cmp_r;
  assign out_force   = force_r;

endmodule
`default_nettype wire

### hdl/actuator_safety_interlock_top.sv
// path: after its item is accepted, a result passes the capture, multiply and output registers
// throughput: one item per cycle while results are taken; the output stage holds a
//   result while the earlier stages keep taking items until the pipeline is full
// stages: state update, period times duty multiply, divide-by-100 multiply
// reset: synchronous active low; state clears, config returns to defaults
`default_nettype none
// ----------------------------------------------------------------------------
// actuator_safety_interlock_top
// Safety interlock for a pwm actuator: command and tick items in, status and
// pwm compare results out.
// ----------------------------------------------------------------------------
module actuator_safety_interlock_top import asi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  asi_in_if.sink           in_chan,
  asi_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  status_t     state_nxt;
  status_t     out_status;
  logic [15:0] pwm_period;
  logic        in_ready;
  logic        accept;

  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  asi_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_chan.op),
    .req_sp     ($unsigned(in_chan.requested_setpoint)),
    .seq_in     (in_chan.seq_number),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .state_nxt  (state_nxt),
    .pwm_period (pwm_period)
  );

  asi_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_ready),
    .state_nxt   (state_nxt),
    .pwm_period  (pwm_period),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_status  (out_status),
    .out_compare (out_chan.compare_value),
    .out_force   (out_chan.force_mode)
  );

  assign out_chan.mode            = out_status.mode;
  assign out_chan.fault_code      = out_status.fault_code;
  assign out_chan.drive_enabled   = out_status.drive_enabled;
  assign out_chan.fault_held      = out_status.fault_held;
  assign out_chan.active_setpoint = out_status.active_setpoint;
  assign out_chan.duty_percent    = out_status.duty_percent;
  assign out_chan.command_age     = out_status.command_age;
  assign out_chan.last_seq        = out_status.last_seq;

endmodule
`default_nettype wire

### hdl/asi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asi_checker
// Port-level checks on the interlock, bound to the top level.
// ----------------------------------------------------------------------------
module asi_checker import asi_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_op,
  input wire logic [15:0] in_sp,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_mode,
  input wire logic [2:0]  out_fault_code,
  input wire logic        out_drive_enabled,
  input wire logic        out_fault_held,
  input wire logic [15:0] out_compare
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_compare) && $stable(out_mode))
    else $error("result changed while stalled");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an overflow item always comes out with a latched fault
  a_overflow_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_OVERFLOW) ##1 out_ready ##1 out_ready
    |=> out_valid && out_fault_held && out_mode == MODE_FAULT && !out_drive_enabled)
    else $error("overflow did not latch a fault");

  // a negative setpoint on enable latches the setpoint fault
  a_neg_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_ENABLE && in_sp[15]) ##1 out_ready ##1 out_ready
    |=> out_valid && out_fault_code == FLT_SETPOINT && out_compare == 16'd0)
    else $error("negative setpoint not rejected");

endmodule

bind actuator_safety_interlock_top asi_checker u_asi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_op             (in_chan.op),
  .in_sp             (in_chan.requested_setpoint),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_mode          (out_chan.mode),
  .out_fault_code    (out_chan.fault_code),
  .out_drive_enabled (out_chan.drive_enabled),
  .out_fault_held    (out_chan.fault_held),
  .out_compare       (out_chan.compare_value)
);
`default_nettype wire

### tb/tb_actuator_safety_interlock_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_actuator_safety_interlock_top
// Drives command and tick items into the interlock at random pace, predicts
// each status result from a behavioural copy of the interlock state and
// checks every field of every result item in order.
// ----------------------------------------------------------------------------
module tb_actuator_safety_interlock_top;
  import asi_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] setpoint;
    logic [15:0] seq;
  } cmd_t;

  typedef struct {
    logic [1:0]  mode;
    logic [2:0]  fault;
    logic        drive;
    logic        held;
    logic [9:0]  setpoint;
    logic [6:0]  duty;
    logic [15:0] age;
    logic [15:0] seq;
    logic [15:0] compare;
    logic [1:0]  force_md;
  } status_word_t;

  localparam int STALL_LIMIT = 1000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  asi_in_if  in_chan();
  asi_out_if out_chan();

  actuator_safety_interlock_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // interlock copy: configuration
  logic [9:0]  lim_cfg     = LIMIT_RST;
  logic [15:0] timeout_cfg = TIMEOUT_RST;
  logic [15:0] period_cfg  = PERIOD_RST;

  // interlock copy: state
  logic [1:0]  mode_q  = MODE_READY;
  logic [2:0]  fault_q = FLT_NONE;
  logic        drive_q = 1'b0;
  logic        held_q  = 1'b0;
  logic [9:0]  setpt_q = '0;
  logic [6:0]  duty_q  = '0;
  logic [15:0] age_q   = '0;
  logic [15:0] seq_q   = '0;

  cmd_t         cmd_backlog[$];
  status_word_t status_due[$];
  cmd_t         drv_cmd;

  int  cmds_queued    = 0;
  int  cmds_in_flight = 0;
  int  err_count      = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  calm_left      = 0;
  int  quiet_cycles   = 0;
  bit  calm           = 1'b0;
  bit  cmd_taken      = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("%0t ns: error: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic trip(input logic [2:0] code);
    fault_q = code;
    held_q  = 1'b1;
    drive_q = 1'b0;
    setpt_q = '0;
    duty_q  = '0;
    mode_q  = MODE_FAULT;
  endtask

  task automatic predict_status(input logic [2:0] op, input logic [15:0] sp,
                                input logic [15:0] seq);
    logic [9:0]   eff_lim;
    logic [31:0]  prod;
    status_word_t w;
    eff_lim = (lim_cfg > SETPOINT_CEIL) ? SETPOINT_CEIL : lim_cfg;
    if (op != OP_TICK && op != OP_OVERFLOW) begin
      age_q = '0;
      seq_q = seq;
    end
    case (op)
      OP_TICK: begin
        if (drive_q && mode_q == MODE_RUN) begin
          if (age_q != AGE_MAX) age_q = age_q + 16'd1;
          if (age_q >= timeout_cfg) trip(FLT_TIMEOUT);
        end
      end
      OP_ENABLE: begin
        if (sp[15] || sp > {6'd0, eff_lim}) begin
          trip(FLT_SETPOINT);
        end else if (held_q) begin
          // latched fault keeps the drive off, code untouched
          duty_q  = '0;
          drive_q = 1'b0;
          mode_q  = MODE_FAULT;
        end else begin
          drive_q = 1'b1;
          setpt_q = sp[9:0];
          duty_q  = 7'(sp[9:0] / 10);
          fault_q = FLT_NONE;
          mode_q  = MODE_RUN;
        end
      end
      OP_DISABLE: begin
        drive_q = 1'b0;
        setpt_q = '0;
        duty_q  = '0;
        if (held_q) begin
          mode_q = MODE_FAULT;
        end else begin
          fault_q = FLT_NONE;
          mode_q  = MODE_READY;
        end
      end
      OP_RESET: begin
        if (!drive_q) begin
          fault_q = FLT_NONE;
          held_q  = 1'b0;
          setpt_q = '0;
          duty_q  = '0;
          mode_q  = MODE_READY;
        end
      end
      OP_FAULT_INJECT: trip(FLT_SENSOR);
      OP_CLEAR: ;
      default: trip(FLT_UNKNOWN);
    endcase

    w.mode     = mode_q;
    w.fault    = fault_q;
    w.drive    = drive_q;
    w.held     = held_q;
    w.setpoint = setpt_q;
    w.duty     = duty_q;
    w.age      = age_q;
    w.seq      = seq_q;
    if (duty_q == '0) begin
      w.compare  = '0;
      w.force_md = FORCE_LOW;
    end else if (duty_q >= DUTY_FULL) begin
      w.compare  = period_cfg;
      w.force_md = FORCE_HIGH;
    end else begin
      prod       = (32'(period_cfg) * 32'(duty_q)) / 32'd100;
      w.compare  = prod[15:0];
      w.force_md = FORCE_NONE;
    end
    status_due.push_back(w);
  endtask

  task automatic check_status();
    status_word_t w;
    if (status_due.size() == 0) begin
      flag_error("result item with nothing expected");
    end else begin
      w = status_due.pop_front();
      check_field("mode", 16'(out_chan.mode), 16'(w.mode));
      check_field("fault_code", 16'(out_chan.fault_code), 16'(w.fault));
      check_field("drive_enabled", 16'(out_chan.drive_enabled), 16'(w.drive));
      check_field("fault_held", 16'(out_chan.fault_held), 16'(w.held));
      check_field("active_setpoint", 16'(out_chan.active_setpoint), 16'(w.setpoint));
      check_field("duty_percent", 16'(out_chan.duty_percent), 16'(w.duty));
      check_field("command_age", out_chan.command_age, w.age);
      check_field("last_seq", out_chan.last_seq, w.seq);
      check_field("compare_value", out_chan.compare_value, w.compare);
      check_field("force_mode", 16'(out_chan.force_mode), 16'(w.force_md));
    end
  endtask

  // mostly short pauses, a few long, none during calm stretches
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // sampling side
  always @(posedge clk) begin
    cmd_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETPOINT_LIMIT: lim_cfg     = cfg_wdata[9:0];
          CFG_TIMEOUT_TICKS:  timeout_cfg = cfg_wdata;
          CFG_PWM_PERIOD:     period_cfg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        cmd_taken = 1'b1;
        cmds_in_flight--;
        predict_status(in_chan.op, in_chan.requested_setpoint, in_chan.seq_number);
      end
      if (out_chan.valid && out_chan.ready) check_status();
    end
    if (calm_left == 0) begin
      calm_left = $urandom_range(50, 200);
      calm      = ($urandom_range(0, 3) == 0);
    end else begin
      calm_left--;
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || cmd_taken) begin
      if (gap_left > 0) begin
        in_chan.valid <= 1'b0;
        gap_left--;
      end else if (cmd_backlog.size() > 0) begin
        drv_cmd = cmd_backlog.pop_front();
        in_chan.valid              <= 1'b1;
        in_chan.op                 <= drv_cmd.op;
        in_chan.requested_setpoint <= drv_cmd.setpoint;
        in_chan.seq_number         <= drv_cmd.seq;
        gap_left = pick_pause();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left--;
    end else begin
      out_chan.ready <= 1'b1;
      stall_left = pick_pause();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [15:0] sp,
                           input logic [15:0] seq);
    cmd_t c;
    c.op       = op;
    c.setpoint = sp;
    c.seq      = seq;
    cmd_backlog.push_back(c);
    cmds_queued++;
    cmds_in_flight++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (cmds_in_flight != 0 || status_due.size() != 0) @(negedge clk);
  endtask

  // called at a falling edge with the interlock idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] lim, input logic [15:0] tmo,
                            input logic [15:0] per);
    write_reg(CFG_SETPOINT_LIMIT, lim);
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    write_reg(CFG_PWM_PERIOD, per);
    cfg_we <= 1'b0;
  endtask

  function automatic int eff_limit();
    return (lim_cfg > SETPOINT_CEIL) ? int'(SETPOINT_CEIL) : int'(lim_cfg);
  endfunction

  function automatic logic [15:0] good_setpoint();
    int lim;
    lim = eff_limit();
    case ($urandom_range(0, 4))
      0: return 16'(lim);
      1: return 16'd0;
      2: return 16'((lim / 10) * 10);
      default: return 16'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic logic [15:0] bad_setpoint();
    int lim;
    lim = eff_limit();
    case ($urandom_range(0, 2))
      0: return 16'(lim + 1);
      1: return 16'($urandom_range(lim + 1, 32767));
      default: return 16'h8000 | 16'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [15:0] any_seq();
    if ($urandom_range(0, 7) == 0) return 16'd0;
    return 16'($urandom);
  endfunction

  // disable, reset, enable, then a run of ticks and commands with a random ending
  task automatic add_session();
    int n;
    int r;
    queue_cmd(OP_DISABLE, 16'($urandom), any_seq());
    queue_cmd(OP_RESET, 16'($urandom), any_seq());
    queue_cmd(OP_ENABLE, good_setpoint(), any_seq());
    n = $urandom_range(0, (timeout_cfg > 37) ? 40 : int'(timeout_cfg) + 3);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75)      queue_cmd(OP_TICK, 16'($urandom), 16'($urandom));
      else if (r < 85) queue_cmd(OP_CLEAR, 16'($urandom), any_seq());
      else if (r < 93) queue_cmd(OP_ENABLE, good_setpoint(), any_seq());
      else             queue_cmd(OP_RESET, 16'($urandom), any_seq());
    end
    case ($urandom_range(0, 5))
      0: queue_cmd(OP_DISABLE, 16'($urandom), any_seq());
      1: queue_cmd(OP_FAULT_INJECT, 16'($urandom), any_seq());
      2: queue_cmd(OP_ENABLE, bad_setpoint(), any_seq());
      3: queue_cmd(OP_OVERFLOW, 16'($urandom), 16'($urandom));
      4: queue_cmd(OP_UNKNOWN, 16'($urandom), any_seq());
      default: ;
    endcase
  endtask

  initial begin
    int base;
    rst_n                      = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = CFG_SETPOINT_LIMIT;
    cfg_wdata                  = '0;
    in_chan.valid              = 1'b0;
    in_chan.op                 = OP_TICK;
    in_chan.requested_setpoint = '0;
    in_chan.seq_number         = '0;
    out_chan.ready             = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: limit 1000, timeout 3000, period 1000
    queue_cmd(OP_TICK, 16'd0, 16'd0);
    queue_cmd(OP_ENABLE, 16'd1000, 16'hFFFF);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h1234);
    queue_cmd(OP_CLEAR, 16'd0, 16'd1);
    queue_cmd(OP_RESET, 16'd0, 16'd2);  // while running: age and seq only
    queue_cmd(OP_ENABLE, 16'd555, 16'd3);
    queue_cmd(OP_ENABLE, 16'd1001, 16'd4);
    queue_cmd(OP_ENABLE, 16'd500, 16'd5);  // good setpoint but latched
    queue_cmd(OP_ENABLE, 16'hFFFF, 16'd6);  // negative overwrites the code
    queue_cmd(OP_FAULT_INJECT, 16'd0, 16'd7);
    queue_cmd(OP_DISABLE, 16'd0, 16'd8);
    queue_cmd(OP_RESET, 16'd0, 16'd9);
    queue_cmd(OP_UNKNOWN, 16'd0, 16'd10);
    queue_cmd(OP_RESET, 16'd0, 16'd11);
    queue_cmd(OP_OVERFLOW, 16'h7FFF, 16'hABCD);
    queue_cmd(OP_RESET, 16'd0, 16'd0);
    queue_cmd(OP_ENABLE, 16'h8000, 16'd12);
    wait_idle();

    // limit above range acts as 1000, zero timeout, zero period
    set_config(16'hFFFF, 16'd0, 16'd0);
    queue_cmd(OP_RESET, 16'd0, 16'd13);
    queue_cmd(OP_ENABLE, 16'd1000, 16'd14);
    queue_cmd(OP_ENABLE, 16'd1001, 16'd15);
    queue_cmd(OP_RESET, 16'd0, 16'd16);
    queue_cmd(OP_ENABLE, 16'd37, 16'd17);
    queue_cmd(OP_TICK, 16'd0, 16'd0);
    wait_idle();

    set_config(16'd1000, 16'd2, 16'hFFFF);
    queue_cmd(OP_RESET, 16'd0, 16'd18);
    queue_cmd(OP_ENABLE, 16'd999, 16'd19);
    queue_cmd(OP_TICK, 16'd0, 16'd0);
    queue_cmd(OP_TICK, 16'd0, 16'd0);

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(16'd1000, 16'($urandom_range(2, 25)), 16'd1000);
        1: set_config(16'd0, 16'd1, 16'hFFFF);
        2: set_config(16'd1023, 16'hFFFF, 16'd1);
        3: set_config(16'($urandom_range(1, 999)), 16'($urandom_range(5, 40)),
                      16'($urandom_range(1, 65535)));
        default: set_config(16'($urandom_range(0, 1023)), 16'($urandom_range(1, 15)),
                            16'($urandom_range(0, 65535)));
      endcase
      @(negedge clk);
      base = cmds_queued;
      while (cmds_queued - base < 80) begin
        if ($urandom_range(0, 3) != 0) begin
          add_session();
        end else begin
          // noise: anything at all
          repeat ($urandom_range(1, 6))
            queue_cmd(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
